### design/ptu_pkg.sv
// shared types, constants and helper functions for the page table update engine
package ptu_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int ENTRIES     = 512;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int ADDR_W      = SLOT_W + IDX_W;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int FRAME_W     = 40;

	localparam logic [1:0] CMD_MAP   = 2'd0;
	localparam logic [1:0] CMD_UNMAP = 2'd1;
	localparam logic [1:0] CMD_ATTR  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NOT_PRES = 2'd2;
	localparam logic [1:0] ST_NO_SPACE = 2'd3;

	localparam int B_P   = 0;
	localparam int B_RW  = 1;
	localparam int B_US  = 2;
	localparam int B_PWT = 3;
	localparam int B_PCD = 4;
	localparam int B_PS  = 7;
	localparam int B_G   = 8;
	localparam int B_PATL = 12;
	localparam int B_NX  = 63;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        vaddr;
		logic [FRAME_W-1:0] frame;
		logic [1:0]         size_sel;
		logic               writable;
		logic               user;
		logic               no_exec;
		logic               write_through;
		logic               cache_off;
		logic               global_map;
		logic               pat;
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [63:0]       wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [IDX_W-1:0] lvl_idx(input logic [63:0] va, input logic [1:0] lv);
		logic [IDX_W-1:0] r;
		case (lv)
			2'd0:    r = va[47:39];
			2'd1:    r = va[38:30];
			2'd2:    r = va[29:21];
			default: r = va[20:12];
		endcase
		return r;
	endfunction

	function automatic logic [63:0] attr_bits(input cmd_t c, input logic leaf);
		logic [63:0] a;
		a = '0;
		a[B_RW]  = c.writable;
		a[B_US]  = c.user;
		a[B_NX]  = c.no_exec;
		a[B_PWT] = c.write_through;
		a[B_PCD] = c.cache_off;
		a[B_G]   = c.global_map;
		if (leaf) begin
			a[B_PS] = c.pat;
		end else begin
			a[B_PATL] = c.pat;
		end
		return a;
	endfunction

	function automatic logic [63:0] keep_mask(input logic leaf);
		logic [63:0] k;
		k = '0;
		k[B_RW]  = 1'b1;
		k[B_US]  = 1'b1;
		k[B_NX]  = 1'b1;
		k[B_PWT] = 1'b1;
		k[B_PCD] = 1'b1;
		k[B_G]   = 1'b1;
		if (leaf) begin
			k[B_PS] = 1'b1;
		end else begin
			k[B_PATL] = 1'b1;
		end
		return k;
	endfunction

endpackage

### design/ptu_ram.sv
// single write port, single registered read port table memory
module ptu_ram #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/ptu_seq.sv
// sequencer: table walk, slot allocation, table clear and emptiness scan over one memory port
module ptu_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  ptu_pkg::cmd_t                 cmd_in,
	input  logic [ptu_pkg::FRAME_W-1:0]   base,
	output logic                          busy,
	output logic                          done,
	output logic [1:0]                    status,
	output logic                          flush_tlb,
	output ptu_pkg::mem_req_t             mreq,
	input  logic [63:0]                   rdata
);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_WRD   = 4'd3;
	localparam logic [3:0] S_WCHK  = 4'd4;
	localparam logic [3:0] S_FREE  = 4'd5;
	localparam logic [3:0] S_ALLOC = 4'd6;
	localparam logic [3:0] S_CLR   = 4'd7;
	localparam logic [3:0] S_LEAF  = 4'd8;
	localparam logic [3:0] S_SCAN  = 4'd9;
	localparam logic [3:0] S_PRD   = 4'd10;
	localparam logic [3:0] S_PWR   = 4'd11;

	localparam int SW = ptu_pkg::SLOT_W;
	localparam int IW = ptu_pkg::IDX_W;

	logic [3:0]                       state_q;
	ptu_pkg::cmd_t                    c_q;
	logic [1:0]                       lv_q;
	logic [1:0]                       leaf_lv_q;
	logic [1:0]                       need_q;
	logic [SW-1:0]                    path_q [4];
	logic [ptu_pkg::TABLE_SLOTS-1:0]  inuse_q;
	logic [IW:0]                      cnt_q;
	logic                             pend_q;
	logic                             done_q;
	logic [1:0]                       status_q;
	logic                             flush_q;

	// helpers on the entry just read
	logic [ptu_pkg::FRAME_W-1:0] ch_d;
	logic                        ch_ok;
	logic                        e_p;
	logic                        e_ps;
	logic [ptu_pkg::CNT_W-1:0]   free_cnt;
	logic [SW-1:0]               low_free;
	logic [IW-1:0]               idx_cur;
	logic [IW-1:0]               idx_up;
	logic [1:0]                  lv_up;
	logic [1:0]                  lv_nx;
	logic                        canon;
	logic                        bad_req;
	logic [63:0]                 ptr_ent;
	logic [63:0]                 leaf_ent;
	logic [ptu_pkg::FRAME_W-1:0] ptr_frame;

	assign e_p   = rdata[ptu_pkg::B_P];
	assign e_ps  = rdata[ptu_pkg::B_PS];
	assign ch_d  = rdata[51:12] - base;
	assign ch_ok = (ch_d != '0) && (ch_d < ptu_pkg::FRAME_W'(ptu_pkg::TABLE_SLOTS))
		&& inuse_q[ch_d[SW-1:0]];
	assign lv_up   = lv_q - 2'd1;
	assign lv_nx   = lv_q + 2'd1;
	assign idx_cur = ptu_pkg::lvl_idx(c_q.vaddr, lv_q);
	assign idx_up  = ptu_pkg::lvl_idx(c_q.vaddr, lv_up);
	assign canon   = (c_q.vaddr[63:47] == '0) || (c_q.vaddr[63:47] == '1);

	always_comb begin
		free_cnt = '0;
		low_free = '0;
		for (int i = ptu_pkg::TABLE_SLOTS - 1; i >= 1; i--) begin
			if (!inuse_q[i]) begin
				free_cnt = free_cnt + ptu_pkg::CNT_W'(1);
				low_free = SW'(i);
			end
		end
	end

	always_comb begin
		bad_req = 1'b0;
		case (c_q.cmd)
			ptu_pkg::CMD_MAP: begin
				case (c_q.size_sel)
					2'd0: bad_req = c_q.vaddr[11:0] != '0;
					2'd1: bad_req = (c_q.vaddr[20:0] != '0) || (c_q.frame[8:0] != '0);
					2'd2: bad_req = (c_q.vaddr[29:0] != '0) || (c_q.frame[17:0] != '0);
					default: bad_req = 1'b1;
				endcase
			end
			ptu_pkg::CMD_UNMAP: bad_req = c_q.vaddr[11:0] != '0;
			ptu_pkg::CMD_ATTR:  bad_req = 1'b0;
			default:            bad_req = 1'b1;
		endcase
		if (!canon) begin
			bad_req = 1'b1;
		end
	end

	assign ptr_frame = base + ptu_pkg::FRAME_W'(low_free);

	always_comb begin
		ptr_ent = '0;
		ptr_ent[ptu_pkg::B_P]  = 1'b1;
		ptr_ent[ptu_pkg::B_RW] = 1'b1;
		ptr_ent[ptu_pkg::B_US] = 1'b1;
		ptr_ent[11:9]  = 3'd4 - 3'(lv_q);
		ptr_ent[51:12] = ptr_frame;
		leaf_ent = ptu_pkg::attr_bits(c_q, leaf_lv_q == 2'd3);
		leaf_ent[ptu_pkg::B_P] = 1'b1;
		leaf_ent[ptu_pkg::B_PS] = (leaf_lv_q != 2'd3) | leaf_ent[ptu_pkg::B_PS];
		leaf_ent[11:9]  = 3'd4 - 3'(leaf_lv_q);
		leaf_ent[51:12] = c_q.frame;
	end

	// memory port requests
	always_comb begin
		mreq = '0;
		case (state_q)
			S_INIT: begin
				mreq.we    = 1'b1;
				mreq.waddr = {SW'(0), cnt_q[IW-1:0]};
			end
			S_WRD: begin
				mreq.re    = 1'b1;
				mreq.raddr = {path_q[lv_q], idx_cur};
			end
			S_WCHK: begin
				mreq.waddr = {path_q[lv_q], idx_cur};
				if (c_q.cmd != ptu_pkg::CMD_MAP && e_p
					&& (lv_q == 2'd3 || (lv_q != 2'd0 && e_ps))) begin
					mreq.we = 1'b1;
					if (c_q.cmd == ptu_pkg::CMD_ATTR) begin
						mreq.wdata = (rdata & ~ptu_pkg::keep_mask(lv_q == 2'd3))
							| ptu_pkg::attr_bits(c_q, lv_q == 2'd3);
					end else begin
						mreq.wdata = rdata & ~64'd1;
					end
				end
			end
			S_ALLOC: begin
				mreq.we    = 1'b1;
				mreq.waddr = {path_q[lv_q], idx_cur};
				mreq.wdata = ptr_ent;
			end
			S_CLR: begin
				mreq.we    = 1'b1;
				mreq.waddr = {path_q[lv_nx], cnt_q[IW-1:0]};
			end
			S_LEAF: begin
				mreq.we    = 1'b1;
				mreq.waddr = {path_q[leaf_lv_q], ptu_pkg::lvl_idx(c_q.vaddr, leaf_lv_q)};
				mreq.wdata = leaf_ent;
			end
			S_SCAN: begin
				mreq.re    = !cnt_q[IW];
				mreq.raddr = {path_q[lv_q], cnt_q[IW-1:0]};
			end
			S_PRD: begin
				mreq.re    = 1'b1;
				mreq.raddr = {path_q[lv_up], idx_up};
			end
			S_PWR: begin
				mreq.we    = 1'b1;
				mreq.waddr = {path_q[lv_up], idx_up};
				mreq.wdata = rdata & ~64'd1;
			end
			default: mreq = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			c_q <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			lv_q      <= '0;
			leaf_lv_q <= '0;
			need_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				path_q[i] <= '0;
			end
			inuse_q   <= ptu_pkg::TABLE_SLOTS'(1);
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ptu_pkg::ST_OK;
			flush_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + (IW+1)'(1);
					if (cnt_q[IW-1:0] == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					lv_q      <= '0;
					path_q[0] <= '0;
					leaf_lv_q <= 2'd3 - c_q.size_sel;
					if (bad_req) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ptu_pkg::ST_INVALID;
						flush_q  <= 1'b0;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= S_WCHK;
				S_WCHK: begin
					if (c_q.cmd == ptu_pkg::CMD_MAP) begin
						if (lv_q != leaf_lv_q) begin
							if (!e_p) begin
								need_q  <= leaf_lv_q - lv_q;
								state_q <= S_FREE;
							end else if ((lv_q != 2'd0 && e_ps) || !ch_ok) begin
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
								status_q <= ptu_pkg::ST_INVALID;
								flush_q  <= 1'b0;
							end else begin
								path_q[lv_nx] <= ch_d[SW-1:0];
								lv_q          <= lv_nx;
								state_q       <= S_WRD;
							end
						end else if (leaf_lv_q != 2'd3 && e_p && !e_ps) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= ptu_pkg::ST_INVALID;
							flush_q  <= 1'b0;
						end else begin
							need_q  <= '0;
							state_q <= S_FREE;
						end
					end else begin
						if (!e_p) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= (c_q.cmd == ptu_pkg::CMD_ATTR) ?
								ptu_pkg::ST_NOT_PRES : ptu_pkg::ST_OK;
							flush_q  <= 1'b0;
						end else if (lv_q == 2'd3 || (lv_q != 2'd0 && e_ps)) begin
							if (c_q.cmd == ptu_pkg::CMD_ATTR) begin
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
								status_q <= ptu_pkg::ST_OK;
								flush_q  <= 1'b1;
							end else begin
								cnt_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= S_SCAN;
							end
						end else if (!ch_ok) begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= ptu_pkg::ST_INVALID;
							flush_q  <= 1'b0;
						end else begin
							path_q[lv_nx] <= ch_d[SW-1:0];
							lv_q          <= lv_nx;
							state_q       <= S_WRD;
						end
					end
				end
				S_FREE: begin
					if (ptu_pkg::CNT_W'(need_q) > free_cnt) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ptu_pkg::ST_NO_SPACE;
						flush_q  <= 1'b0;
					end else if (need_q == '0) begin
						state_q <= S_LEAF;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					inuse_q[low_free] <= 1'b1;
					path_q[lv_nx]     <= low_free;
					cnt_q             <= '0;
					state_q           <= S_CLR;
				end
				S_CLR: begin
					cnt_q <= cnt_q + (IW+1)'(1);
					if (cnt_q[IW-1:0] == '1) begin
						lv_q <= lv_nx;
						if (lv_nx == leaf_lv_q) begin
							state_q <= S_LEAF;
						end else begin
							state_q <= S_ALLOC;
						end
					end
				end
				S_LEAF: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= ptu_pkg::ST_OK;
					flush_q  <= 1'b1;
				end
				S_SCAN: begin
					pend_q <= !cnt_q[IW];
					if (!cnt_q[IW]) begin
						cnt_q <= cnt_q + (IW+1)'(1);
					end
					if (pend_q && rdata[ptu_pkg::B_P]) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ptu_pkg::ST_OK;
						flush_q  <= 1'b1;
					end else if (cnt_q[IW] && !pend_q) begin
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PWR;
				S_PWR: begin
					inuse_q[path_q[lv_q]] <= 1'b0;
					lv_q <= lv_up;
					if (lv_up == 2'd0) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ptu_pkg::ST_OK;
						flush_q  <= 1'b1;
					end else begin
						cnt_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign status    = status_q;
	assign flush_tlb = flush_q;

endmodule

### design/page_table_update_engine_top.sv
// top level of the page table update engine: ports, base register, sequencer and table memory
// Keeps four-level x86-64 page tables in an on-chip store of 16 table slots of 512
// entries, slot 0 being the root. A command is taken when start is high and busy is
// low; busy stays high until the one result is shown, for a single cycle, on done with
// status and flush_tlb. The receiver cannot stall, so it must take the result in that
// cycle. All work goes through one table memory port, so the time per command depends
// on the walk: a rejected command ends after the request check, a walk reads one entry
// per level, each newly allocated table is cleared entry by entry, and an unmap scans
// each table that it checks and clears the pointer to each table found empty. After
// reset the root slot is cleared while busy is high.
// The base frame register is written over cfg_valid/cfg_data and should only change
// while the block is idle.
module page_table_update_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	// command transfer
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] vaddr,
	input  logic [39:0] frame,
	input  logic [1:0]  size_sel,
	input  logic        writable,
	input  logic        user,
	input  logic        no_exec,
	input  logic        write_through,
	input  logic        cache_off,
	input  logic        global_map,
	input  logic        pat,
	// result transfer, one-cycle strobe
	output logic        done,
	output logic [1:0]  status,
	output logic        flush_tlb,
	// base frame register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [39:0] cfg_data
);

	ptu_pkg::cmd_t                 cmd_in;
	ptu_pkg::mem_req_t             mreq;
	logic [63:0]                   rdata;
	logic [ptu_pkg::FRAME_W-1:0]   base_q;

	// frame number of table slot zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// gather the command fields
	always_comb begin
		cmd_in.cmd           = cmd;
		cmd_in.vaddr         = vaddr;
		cmd_in.frame         = frame;
		cmd_in.size_sel      = size_sel;
		cmd_in.writable      = writable;
		cmd_in.user          = user;
		cmd_in.no_exec       = no_exec;
		cmd_in.write_through = write_through;
		cmd_in.cache_off     = cache_off;
		cmd_in.global_map    = global_map;
		cmd_in.pat           = pat;
	end

	ptu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd_in    (cmd_in),
		.base      (base_q),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.flush_tlb (flush_tlb),
		.mreq      (mreq),
		.rdata     (rdata)
	);

	// table store, one entry per slot and index
	ptu_ram #(
		.ADDR_W (ptu_pkg::ADDR_W),
		.DATA_W (64)
	) u_ram (
		.clk   (clk),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (rdata)
	);

endmodule

### tb/page_table_update_engine_top_test.sv
// self-checking testbench for the page table update engine: directed and random commands
module page_table_update_engine_top_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [63:0] LOW_4K = 64'hFFF;
	localparam logic [63:0] LOW_2M = 64'h1F_FFFF;
	localparam logic [63:0] LOW_1G = 64'h3FFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [63:0] vaddr;
	logic [39:0] frame;
	logic [1:0]  size_sel;
	logic        writable, user, no_exec, write_through, cache_off, global_map, pat;
	logic        done;
	logic [1:0]  status;
	logic        flush_tlb;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [39:0] cfg_data;

	page_table_update_engine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .cmd(cmd), .vaddr(vaddr), .frame(frame),
		.size_sel(size_sel), .writable(writable), .user(user), .no_exec(no_exec),
		.write_through(write_through), .cache_off(cache_off), .global_map(global_map),
		.pat(pat), .done(done), .status(status), .flush_tlb(flush_tlb),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// shadow page tables: entries never written read as zero
	// ---------------------------------------------------------------
	typedef struct {
		logic [1:0] status;
		logic       flush;
	} outcome_t;

	logic [63:0]                     shadow_entries [int];
	logic [ptu_pkg::TABLE_SLOTS-1:0] shadow_used;
	logic [39:0]                     shadow_base;
	outcome_t                        pending_outcomes [$];

	int mismatches, items_sent, results_seen, cfg_writes;
	int status_hits [4];
	int flush_hits;
	int idle_cycles;
	logic saw_transfer;

	function automatic logic [63:0] entry_rd(int slot, int ix);
		int a;
		a = slot * ptu_pkg::ENTRIES + ix;
		return shadow_entries.exists(a) ? shadow_entries[a] : 64'd0;
	endfunction

	function automatic void entry_wr(int slot, int ix, logic [63:0] v);
		shadow_entries[slot * ptu_pkg::ENTRIES + ix] = v;
	endfunction

	function automatic int level_ix(logic [63:0] va, int lv);
		return int'(va[47 - 9 * lv -: 9]);
	endfunction

	// slot named by a table pointer, or -1 when it names no live lower table
	function automatic int pointed_slot(logic [63:0] e);
		logic [39:0] d;
		d = e[51:12] - shadow_base;
		if (d == 0 || d >= ptu_pkg::TABLE_SLOTS) return -1;
		if (!shadow_used[d]) return -1;
		return int'(d);
	endfunction

	function automatic logic table_is_empty(int slot);
		logic [63:0] e;
		for (int i = 0; i < ptu_pkg::ENTRIES; i++) begin
			e = entry_rd(slot, i);
			if (e[ptu_pkg::B_P]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int free_slots();
		int n;
		n = 0;
		for (int i = 1; i < ptu_pkg::TABLE_SLOTS; i++)
			if (!shadow_used[i]) n++;
		return n;
	endfunction

	function automatic int grab_slot();
		for (int i = 1; i < ptu_pkg::TABLE_SLOTS; i++) begin
			if (!shadow_used[i]) begin
				shadow_used[i] = 1'b1;
				for (int k = 0; k < ptu_pkg::ENTRIES; k++) entry_wr(i, k, 64'd0);
				return i;
			end
		end
		return 0;
	endfunction

	function automatic logic [63:0] perm_bits(ptu_pkg::cmd_t c, logic leaf);
		logic [63:0] a;
		a = '0;
		a[ptu_pkg::B_RW] = c.writable;
		a[ptu_pkg::B_US] = c.user;
		a[ptu_pkg::B_NX] = c.no_exec;
		a[ptu_pkg::B_PWT] = c.write_through;
		a[ptu_pkg::B_PCD] = c.cache_off;
		a[ptu_pkg::B_G] = c.global_map;
		if (leaf) a[ptu_pkg::B_PS] = c.pat;
		else a[ptu_pkg::B_PATL] = c.pat;
		return a;
	endfunction

	function automatic logic [1:0] shadow_map(ptu_pkg::cmd_t c);
		int leaf_lv, need, s;
		int path [4];
		logic [63:0] e, ent;
		if (c.size_sel > 2) return ptu_pkg::ST_INVALID;
		leaf_lv = 3 - int'(c.size_sel);
		if (c.size_sel == 0 && (c.vaddr & LOW_4K) != 0) return ptu_pkg::ST_INVALID;
		if (c.size_sel == 1 && ((c.vaddr & LOW_2M) != 0 || c.frame[8:0] != 0))
			return ptu_pkg::ST_INVALID;
		if (c.size_sel == 2 && ((c.vaddr & LOW_1G) != 0 || c.frame[17:0] != 0))
			return ptu_pkg::ST_INVALID;
		path = '{0, 0, 0, 0};
		need = 0;
		for (int lv = 0; lv < leaf_lv; lv++) begin
			e = entry_rd(path[lv], level_ix(c.vaddr, lv));
			if (!e[ptu_pkg::B_P]) begin
				need = leaf_lv - lv;
				break;
			end
			// a large page sits in the way of a deeper map
			if (lv >= 1 && e[ptu_pkg::B_PS]) return ptu_pkg::ST_INVALID;
			s = pointed_slot(e);
			if (s < 0) return ptu_pkg::ST_INVALID;
			path[lv + 1] = s;
		end
		// a large map may not cover a present lower table
		if (need == 0 && leaf_lv < 3) begin
			e = entry_rd(path[leaf_lv], level_ix(c.vaddr, leaf_lv));
			if (e[ptu_pkg::B_P] && !e[ptu_pkg::B_PS]) return ptu_pkg::ST_INVALID;
		end
		if (need > free_slots()) return ptu_pkg::ST_NO_SPACE;
		for (int lv = 0; lv < leaf_lv; lv++) begin
			e = entry_rd(path[lv], level_ix(c.vaddr, lv));
			if (!e[ptu_pkg::B_P]) begin
				s = grab_slot();
				ent = 64'd0;
				ent[ptu_pkg::B_P] = 1'b1;
				ent[ptu_pkg::B_RW] = 1'b1;
				ent[ptu_pkg::B_US] = 1'b1;
				ent[11:9] = 3'(4 - lv);
				ent[51:12] = shadow_base + 40'(s);
				entry_wr(path[lv], level_ix(c.vaddr, lv), ent);
				path[lv + 1] = s;
			end else begin
				path[lv + 1] = pointed_slot(e);
			end
		end
		ent = 64'd0;
		ent[ptu_pkg::B_P] = 1'b1;
		ent[11:9] = 3'(4 - leaf_lv);
		ent[51:12] = c.frame;
		if (leaf_lv < 3) ent[ptu_pkg::B_PS] = 1'b1;
		ent |= perm_bits(c, leaf_lv == 3);
		entry_wr(path[leaf_lv], level_ix(c.vaddr, leaf_lv), ent);
		return ptu_pkg::ST_OK;
	endfunction

	// walk to the entry mapping va
	function automatic logic [1:0] walk_to_page(logic [63:0] va, output int path [4],
			output int leaf_lv);
		logic [63:0] e;
		int s;
		path = '{0, 0, 0, 0};
		leaf_lv = 0;
		for (int lv = 0; lv < 4; lv++) begin
			e = entry_rd(path[lv], level_ix(va, lv));
			if (!e[ptu_pkg::B_P]) return ptu_pkg::ST_NOT_PRES;
			if (lv == 3 || (lv >= 1 && e[ptu_pkg::B_PS])) begin
				leaf_lv = lv;
				return ptu_pkg::ST_OK;
			end
			s = pointed_slot(e);
			if (s < 0) return ptu_pkg::ST_INVALID;
			path[lv + 1] = s;
		end
		return ptu_pkg::ST_NOT_PRES;
	endfunction

	function automatic outcome_t predict_outcome(ptu_pkg::cmd_t c);
		outcome_t o;
		int path [4];
		int leaf_lv;
		logic [63:0] e, keep;
		logic [1:0] w;
		o.status = ptu_pkg::ST_OK;
		o.flush = 1'b0;
		if (!(c.vaddr[63:47] == '0 || c.vaddr[63:47] == '1)) begin
			o.status = ptu_pkg::ST_INVALID;
		end else if (c.cmd == ptu_pkg::CMD_MAP) begin
			o.status = shadow_map(c);
			o.flush = (o.status == ptu_pkg::ST_OK);
		end else if (c.cmd == ptu_pkg::CMD_UNMAP) begin
			if ((c.vaddr & LOW_4K) != 0) begin
				o.status = ptu_pkg::ST_INVALID;
			end else begin
				w = walk_to_page(c.vaddr, path, leaf_lv);
				if (w == ptu_pkg::ST_INVALID) begin
					o.status = ptu_pkg::ST_INVALID;
				end else if (w == ptu_pkg::ST_OK) begin
					e = entry_rd(path[leaf_lv], level_ix(c.vaddr, leaf_lv));
					e[ptu_pkg::B_P] = 1'b0;
					entry_wr(path[leaf_lv], level_ix(c.vaddr, leaf_lv), e);
					// release tables left with nothing present
					for (int lv = leaf_lv; lv >= 1; lv--) begin
						if (!table_is_empty(path[lv])) break;
						e = entry_rd(path[lv - 1], level_ix(c.vaddr, lv - 1));
						e[ptu_pkg::B_P] = 1'b0;
						entry_wr(path[lv - 1], level_ix(c.vaddr, lv - 1), e);
						shadow_used[path[lv]] = 1'b0;
					end
					o.flush = 1'b1;
				end
			end
		end else if (c.cmd == ptu_pkg::CMD_ATTR) begin
			w = walk_to_page(c.vaddr, path, leaf_lv);
			o.status = w;
			if (w == ptu_pkg::ST_OK) begin
				keep = ptu_pkg::keep_mask(leaf_lv == 3);
				e = entry_rd(path[leaf_lv], level_ix(c.vaddr, leaf_lv));
				e = (e & ~keep) | perm_bits(c, leaf_lv == 3);
				entry_wr(path[leaf_lv], level_ix(c.vaddr, leaf_lv), e);
				o.flush = 1'b1;
			end
		end else begin
			o.status = ptu_pkg::ST_INVALID;
		end
		return o;
	endfunction

	// ---------------------------------------------------------------
	// result checker: results show for one cycle, sampled mid-cycle
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		outcome_t want;
		saw_transfer = (start && !busy) || done || (cfg_valid && cfg_ready);
		if (arst_n && done) begin
			results_seen++;
			status_hits[status]++;
			if (flush_tlb) flush_hits++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: status %0d flush %0b",
						status, flush_tlb);
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status || flush_tlb !== want.flush) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected status %0d flush %0b, got %0d %0b",
							results_seen, want.status, want.flush, status, flush_tlb);
				end
			end
		end
	end

	// watchdog: cycles in which no transfer of any kind happens
	always @(posedge clk) begin
		if (saw_transfer) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// command transfer: called at a rising edge, returns at the accepting edge
	// ---------------------------------------------------------------
	task automatic send_command(ptu_pkg::cmd_t c);
		logic taken;
		start <= 1'b1;
		cmd <= c.cmd;
		vaddr <= c.vaddr;
		frame <= c.frame;
		size_sel <= c.size_sel;
		writable <= c.writable;
		user <= c.user;
		no_exec <= c.no_exec;
		write_through <= c.write_through;
		cache_off <= c.cache_off;
		global_map <= c.global_map;
		pat <= c.pat;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		pending_outcomes.push_back(predict_outcome(c));
		items_sent++;
	endtask

	task automatic pause_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every outstanding result is back and the block is idle
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_table_base(logic [39:0] v);
		logic taken;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		shadow_base = v;
		cfg_writes++;
		@(posedge clk);
	endtask

	function automatic ptu_pkg::cmd_t make_cmd(logic [1:0] op, logic [63:0] va,
			logic [39:0] fr, logic [1:0] sz, logic [6:0] perms);
		ptu_pkg::cmd_t c;
		c.cmd = op;
		c.vaddr = va;
		c.frame = fr;
		c.size_sel = sz;
		{c.writable, c.user, c.no_exec, c.write_through, c.cache_off, c.global_map,
			c.pat} = perms;
		return c;
	endfunction

	// canonical address built from a few table indexes so walks share tables
	function automatic logic [63:0] pick_vaddr();
		int pool [4];
		logic [47:0] lo;
		pool = '{0, 1, 2, 511};
		lo = '0;
		lo[47:39] = 9'(($urandom_range(0, 3) == 0) ? 256 : pool[$urandom_range(0, 3)]);
		lo[38:30] = 9'(pool[$urandom_range(0, 3)]);
		lo[29:21] = 9'(pool[$urandom_range(0, 3)]);
		lo[20:12] = 9'(pool[$urandom_range(0, 3)]);
		return {{16{lo[47]}}, lo};
	endfunction

	function automatic ptu_pkg::cmd_t random_cmd();
		ptu_pkg::cmd_t c;
		int r;
		c = make_cmd(ptu_pkg::CMD_MAP, pick_vaddr(), 40'({$urandom, $urandom}),
			2'($urandom_range(0, 2)), 7'($urandom));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			c.cmd = ptu_pkg::CMD_MAP;
			// mostly aligned large maps, a few misaligned frames
			if (c.size_sel == 1) begin
				c.vaddr[20:0] = '0;
				if ($urandom_range(0, 9) != 0) c.frame[8:0] = '0;
			end else if (c.size_sel == 2) begin
				c.vaddr[29:0] = '0;
				if ($urandom_range(0, 9) != 0) c.frame[17:0] = '0;
			end
		end else if (r < 72) begin
			c.cmd = ptu_pkg::CMD_UNMAP;
			if ($urandom_range(0, 3) == 0) c.vaddr[20:12] = 9'($urandom);
		end else if (r < 92) begin
			c.cmd = ptu_pkg::CMD_ATTR;
			c.vaddr[11:0] = 12'($urandom);
		end else begin
			// noise: odd selectors, stray low bits, arbitrary upper bits
			c.cmd = 2'($urandom);
			c.size_sel = 2'($urandom);
			c.vaddr = {$urandom, $urandom};
		end
		return c;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	task automatic test_basic_walks();
		logic [63:0] hi_half;
		hi_half = 64'hFFFF_8000_0000_0000;
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0, 40'h0, 2'd0, 7'h00));
		// overwrite
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0, 40'hFF_FFFF_FFFF, 2'd0, 7'h7F));
		send_command(make_cmd(ptu_pkg::CMD_ATTR, 64'h123, 40'h0, 2'd0, 7'h55));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h0, 40'h0, 2'd0, 7'h00));
		// absent page
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h0, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_ATTR, 64'h0, 40'h0, 2'd0, 7'h01));
		send_command(make_cmd(ptu_pkg::CMD_MAP, hi_half, 40'h1234, 2'd0, 7'h2A));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, hi_half, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h7FFF_FFFF_F000, 40'h1, 2'd0, 7'h7F));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h7FFF_FFFF_F000, 40'h0, 2'd0, 7'h00));
		// bad selectors, stray address bits, misalignment
		send_command(make_cmd(2'd3, 64'h0, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0, 40'h0, 2'd3, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0000_8000_0000_0000, 40'h0, 2'd0,
			7'h00));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'hFFFF_0000_0000_0000, 40'h0, 2'd0,
			7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h1001, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h20_0000, 40'h1, 2'd1, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h4000_0000, 40'h200, 2'd2, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h801, 40'h0, 2'd0, 7'h00));
	endtask

	task automatic test_large_pages();
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h20_0000, 40'h200, 2'd1, 7'h7F));
		// under 2 MiB
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h21_3000, 40'h5, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_ATTR, 64'h2F_F000, 40'h0, 2'd0, 7'h01));
		// inner address
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h23_4000, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h8000_0000, 40'h4_0000, 2'd2, 7'h15));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h8000_0000, 40'h4_0000, 2'd1, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_ATTR, 64'h8123_4567, 40'h0, 2'd0, 7'h6A));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0, 40'h9, 2'd0, 7'h00));
		// over a table
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0, 40'h0, 2'd1, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0, 40'h0, 2'd2, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h0, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h8000_0000, 40'h0, 2'd0, 7'h00));
	endtask

	// each new top-level index takes three tables, so the store runs out
	task automatic test_store_full();
		for (int i = 0; i < 6; i++)
			send_command(make_cmd(ptu_pkg::CMD_MAP, 64'(i + 10) << 39, 40'(i), 2'd0,
				7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h0000_0500_0000_0000, 40'h0, 2'd2,
			7'h00));
		wait_drained();
		for (int i = 0; i < 6; i++)
			send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'(i + 10) << 39, 40'h0, 2'd0,
				7'h00));
	endtask

	// moving the base frame leaves existing pointers naming the wrong slots
	task automatic test_moved_base();
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h4_0000_0000, 40'h77, 2'd0, 7'h00));
		write_table_base(40'hFF_FFFF_FFFF);
		send_command(make_cmd(ptu_pkg::CMD_ATTR, 64'h4_0000_0000, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h4_0000_0000, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_MAP, 64'h4_0000_1000, 40'h1, 2'd0, 7'h00));
		write_table_base(40'h0);
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h4_0000_0000, 40'h0, 2'd0, 7'h00));
		send_command(make_cmd(ptu_pkg::CMD_UNMAP, 64'h4_0000_1000, 40'h0, 2'd0, 7'h00));
	endtask

	// random traffic in bursts, with random gaps before most bursts
	task automatic test_random_traffic(int count);
		int burst_left;
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 40));
			end
			send_command(random_cmd());
			burst_left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = ptu_pkg::CMD_MAP;
		vaddr = '0;
		frame = '0;
		size_sel = '0;
		{writable, user, no_exec, write_through, cache_off, global_map, pat} = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		flush_hits = 0;
		status_hits = '{0, 0, 0, 0};
		idle_cycles = 0;
		saw_transfer = 1'b0;
		shadow_used = '0;
		shadow_used[0] = 1'b1;
		shadow_base = '0;
		for (int k = 0; k < ptu_pkg::ENTRIES; k++) entry_wr(0, k, 64'd0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_table_base(40'h0);
		test_basic_walks();
		test_large_pages();
		test_store_full();
		test_moved_base();
		test_random_traffic(200);
		write_table_base(40'(({$urandom, $urandom}) & 40'hFF_FFFF_FFFF));
		test_random_traffic(40);
		write_table_base(40'hFF_FFFF_FFFF);
		test_random_traffic(30);
		write_table_base(40'h0);
		test_random_traffic(60);

		wait_drained();
		repeat (40) @(posedge clk);
		$display("sent %0d commands over %0d base settings, %0d results: ok %0d, invalid %0d,",
			items_sent, cfg_writes, results_seen, status_hits[0], status_hits[1]);
		$display("not present %0d, no space %0d, flushes %0d, mismatches %0d",
			status_hits[2], status_hits[3], flush_hits, mismatches);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### sim.f
design/ptu_pkg.sv
design/ptu_ram.sv
design/ptu_seq.sv
design/page_table_update_engine_top.sv
tb/page_table_update_engine_top_test.sv
